### hw/rtl/cds_pkg.sv
`default_nettype none

package cds_pkg;

  // default fraction width of the fixed point format
  localparam int unsigned FracBitsDef = 16;

  // datapath word, wide enough for the capped products and their sums
  localparam int unsigned DW = 44;
  // divisor width: smooth time or decay denominator
  localparam int unsigned DVW = 34;
  // configuration address width
  localparam int unsigned AW = 3;

  typedef logic signed [DW-1:0] word_t;

  // operand and result caps of the fixed point product
  localparam word_t ACap = 44'sh1FFFFFFFF;
  localparam word_t BCap = 44'sh080000000;
  localparam logic [40:0] RCap = 41'h10000000000;
  localparam word_t S32Max = 44'sh0007FFFFFFF;
  localparam word_t S32Min = 44'shFFF80000000;

  // smallest smooth time used by the math
  localparam logic [30:0] StFloor = 31'd7;

  // register indexes, decoded from address bit 2
  localparam logic RegSmoothTime = 1'b0;
  localparam logic RegMaxSpeed = 1'b1;

  // request into the shared multiplier
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  function automatic word_t clamp(word_t v, word_t lo, word_t hi);
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // clamp to the non-negative 31 bit range
  function automatic logic [30:0] clamp31(word_t v);
    if (v < 0) begin
      return 31'd0;
    end else if (v > S32Max) begin
      return 31'h7FFFFFFF;
    end
    return v[30:0];
  endfunction

  function automatic logic signed [31:0] sat32(word_t v);
    if (v > S32Max) begin
      return 32'sh7FFFFFFF;
    end else if (v < S32Min) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic word_t sx32(logic [31:0] v);
    return {{(DW-32){v[31]}}, v};
  endfunction

  function automatic word_t zx31(logic [30:0] v);
    return {{(DW-31){1'b0}}, v};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cds_if.sv
`default_nettype none

// input channel: one position update request
interface cds_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] current_pos;
  logic signed [31:0] target_pos;
  logic [30:0]        delta_time;

  modport source (output valid, output current_pos, output target_pos, output delta_time,
                  input ready);
  modport sink (input valid, input current_pos, input target_pos, input delta_time,
                output ready);
endinterface

// output channel: smoothed position and velocity
interface cds_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos;
  logic signed [31:0] new_velocity;

  modport source (output valid, output new_pos, output new_velocity, input ready);
  modport sink (input valid, input new_pos, input new_velocity, output ready);
endinterface

`default_nettype wire

### hw/rtl/cds_mul.sv
`default_nettype none

// shared fixed point multiplier: clamp, two partial products, shift and cap
module cds_mul #(
  parameter int unsigned FRAC_BITS = cds_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cds_pkg::mul_req_t req_i,
  output logic              busy_o,
  output cds_pkg::word_t    res_o
);

  localparam logic [2:0] PH_ABS = 3'd0;
  localparam logic [2:0] PH_LO  = 3'd1;
  localparam logic [2:0] PH_HI  = 3'd2;
  localparam logic [2:0] PH_ADD = 3'd3;
  localparam logic [2:0] PH_OUT = 3'd4;

  logic           busy_q;
  logic [2:0]     ph_q;
  cds_pkg::word_t a_q, b_q, res_q;
  logic [32:0]    ua_q;
  logic [31:0]    ub_q;
  logic           neg_q;
  logic [48:0]    pp_q;
  logic [64:0]    acc_q;

  cds_pkg::word_t a_c, b_c, res_d;
  logic [32:0]    ua_d;
  logic [31:0]    ub_d;
  logic [16:0]    mop;
  logic [48:0]    prod;
  logic [64:0]    sh;
  logic [40:0]    mag;

  // operand clamp and magnitudes
  always_comb begin
    a_c  = cds_pkg::clamp(a_q, -cds_pkg::ACap, cds_pkg::ACap);
    b_c  = cds_pkg::clamp(b_q, -cds_pkg::BCap, cds_pkg::BCap);
    ua_d = 33'((a_c < 0) ? -a_c : a_c);
    ub_d = 32'((b_c < 0) ? -b_c : b_c);
  end

  // one 17x32 multiplier, low half of a first then high half
  assign mop  = (ph_q == PH_LO) ? ua_q[16:0] : {1'b0, ua_q[32:17]};
  assign prod = {32'd0, mop} * {17'd0, ub_q};

  // drop fraction bits, cap and restore sign
  always_comb begin
    sh    = acc_q >> FRAC_BITS;
    mag   = (sh > {24'd0, cds_pkg::RCap}) ? cds_pkg::RCap : sh[40:0];
    res_d = neg_q ? -{{(cds_pkg::DW-41){1'b0}}, mag} : {{(cds_pkg::DW-41){1'b0}}, mag};
  end

  // phase control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= PH_ABS;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      ph_q   <= PH_ABS;
    end else if (busy_q) begin
      ph_q <= ph_q + 3'd1;
      if (ph_q == PH_OUT) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (busy_q) begin
      case (ph_q)
        PH_ABS: begin
          ua_q  <= ua_d;
          ub_q  <= ub_d;
          neg_q <= (a_c < 0) != (b_c < 0);
        end
        PH_LO: begin
          pp_q <= prod;
        end
        PH_HI: begin
          acc_q <= {16'd0, pp_q};
          pp_q  <= prod;
        end
        PH_ADD: begin
          acc_q <= acc_q + ({16'd0, pp_q} << 17);
        end
        PH_OUT: begin
          res_q <= res_d;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

### hw/rtl/cds_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module cds_div #(
  parameter int unsigned DDW = 34
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DDW-1:0]           dividend_i,
  input  logic [cds_pkg::DVW-1:0]  divisor_i,
  output logic                     busy_o,
  output logic [DDW-1:0]           quot_o
);

  localparam int unsigned CW = $clog2(DDW + 1);

  logic                    busy_q;
  logic [CW-1:0]           cnt_q;
  logic [DDW-1:0]          qd_q;
  logic [cds_pkg::DVW-1:0] rem_q, dvs_q;

  logic [cds_pkg::DVW:0]   rem_sh, rem_nx;
  logic                    fits;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem_q, qd_q[DDW-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  // step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DDW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qd_q  <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      qd_q  <= {qd_q[DDW-2:0], fits};
      rem_q <= rem_nx[cds_pkg::DVW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = qd_q;

endmodule

`default_nettype wire

### hw/rtl/critically_damped_smoother.sv
`default_nettype none

// channel   dir  transfer                               fields
// in_i      in   one update request                     current_pos, target_pos, delta_time
// out_o     out  one smoothed result                    new_pos, new_velocity
// apb       in   register write/read, 4 bytes apart     smooth_time (0x0), max_speed (0x4)
//
// one item takes the omega division of 2*FRAC_BITS+2 steps, eleven products on the
// shared multiplier, and the decay division run beside products six to nine.
// reset clears the velocity to zero, smooth_time to 1.0 and max_speed to full scale.
// in_i is ready only while the sequencer is idle; a finished result waits in the
// output register, and the last step holds until that register is free.
module critically_damped_smoother #(
  parameter int unsigned FRAC_BITS = cds_pkg::FracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  cds_in_if.sink                 in_i,
  cds_out_if.source              out_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [cds_pkg::AW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned DDW = 2 * FRAC_BITS + 2;
  localparam int unsigned EW  = FRAC_BITS + 1;
  localparam cds_pkg::word_t C048 =
    cds_pkg::word_t'(((64'd48 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam cds_pkg::word_t C0235 =
    cds_pkg::word_t'(((64'd235 << FRAC_BITS) + 64'd500) / 64'd1000);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_OMEGA = 5'd1;
  localparam logic [4:0] ST_X     = 5'd2;
  localparam logic [4:0] ST_X2    = 5'd3;
  localparam logic [4:0] ST_X3    = 5'd4;
  localparam logic [4:0] ST_T2    = 5'd5;
  localparam logic [4:0] ST_T3    = 5'd6;
  localparam logic [4:0] ST_MAXC  = 5'd7;
  localparam logic [4:0] ST_CHG   = 5'd8;
  localparam logic [4:0] ST_CO    = 5'd9;
  localparam logic [4:0] ST_TA    = 5'd10;
  localparam logic [4:0] ST_TB    = 5'd11;
  localparam logic [4:0] ST_TO    = 5'd12;
  localparam logic [4:0] ST_WE    = 5'd13;
  localparam logic [4:0] ST_VEL   = 5'd14;
  localparam logic [4:0] ST_POS   = 5'd15;
  localparam logic [4:0] ST_FIN   = 5'd16;

  // control state
  logic [4:0]         state_q, state_d;
  logic [30:0]        smooth_time_q, smooth_time_d;
  logic [30:0]        max_speed_q, max_speed_d;
  logic signed [31:0] velocity_q, velocity_d;
  logic               out_valid_q, out_valid_d;

  // item payload
  logic signed [31:0]      cur_q, cur_d, tgt_q, tgt_d;
  logic [30:0]             dt_q, dt_d, st_q, st_d, omega_d, omega_q;
  logic [30:0]             x_q, x_d, x2_q, x2_d, x3_q, x3_d;
  logic [cds_pkg::DVW-1:0] den_q, den_d;
  logic [EW-1:0]           e_q, e_d;
  cds_pkg::word_t          maxc_q, maxc_d, chg_q, chg_d, tmp_q, tmp_d;
  cds_pkg::word_t          vmt_q, vmt_d, vel_q, vel_d, pos_q, pos_d;
  logic signed [31:0]      out_pos_q, out_pos_d, out_vel_q, out_vel_d;

  // shared units
  cds_pkg::mul_req_t       mreq;
  logic                    mul_busy;
  cds_pkg::word_t          mres;
  logic                    div_start;
  logic [DDW-1:0]          div_dividend, quot;
  logic [cds_pkg::DVW-1:0] div_divisor;
  logic                    div_busy;

  cds_pkg::word_t          pos_f, vel_f;
  logic                    cfg_wr;

  cds_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .busy_o (mul_busy),
    .res_o  (mres)
  );

  cds_div #(
    .DDW(DDW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == cds_pkg::RegMaxSpeed) ? {1'b0, max_speed_q}
                                                     : {1'b0, smooth_time_q};

  always_comb begin
    smooth_time_d = smooth_time_q;
    max_speed_d   = max_speed_q;
    if (cfg_wr) begin
      if (paddr[2] == cds_pkg::RegSmoothTime) begin
        smooth_time_d = pwdata[30:0];
      end else begin
        max_speed_d = pwdata[30:0];
      end
    end
  end

  // overshoot check; the final saturation follows in ST_FIN
  always_comb begin
    pos_f = pos_q;
    vel_f = vel_q;
    if ((tgt_q > cur_q) == (pos_q > cds_pkg::sx32(tgt_q))) begin
      pos_f = cds_pkg::sx32(tgt_q);
      vel_f = '0;
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    velocity_d   = velocity_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    cur_d        = cur_q;
    tgt_d        = tgt_q;
    dt_d         = dt_q;
    st_d         = st_q;
    omega_d      = omega_q;
    x_d          = x_q;
    x2_d         = x2_q;
    x3_d         = x3_q;
    den_d        = den_q;
    e_d          = e_q;
    maxc_d       = maxc_q;
    chg_d        = chg_q;
    tmp_d        = tmp_q;
    vmt_d        = vmt_q;
    vel_d        = vel_q;
    pos_d        = pos_q;
    out_pos_d    = out_pos_q;
    out_vel_d    = out_vel_q;
    mreq         = '0;
    div_start    = 1'b0;
    div_dividend = DDW'(1) << (2 * FRAC_BITS);
    div_divisor  = den_q;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cur_d        = in_i.current_pos;
          tgt_d        = in_i.target_pos;
          dt_d         = in_i.delta_time;
          st_d         = (smooth_time_q < cds_pkg::StFloor) ? cds_pkg::StFloor
                                                            : smooth_time_q;
          div_start    = 1'b1;
          div_dividend = DDW'(1) << (2 * FRAC_BITS + 1);
          div_divisor  = cds_pkg::DVW'(st_d);
          state_d      = ST_OMEGA;
        end
      end
      ST_OMEGA: begin
        if (!div_busy) begin
          omega_d = ((DDW > 31) && (|(quot >> 31))) ? 31'h7FFFFFFF : 31'(quot);
          mreq    = '{start: 1'b1, a: cds_pkg::zx31(omega_d), b: cds_pkg::zx31(dt_q)};
          state_d = ST_X;
        end
      end
      ST_X: begin
        if (!mul_busy) begin
          x_d     = cds_pkg::clamp31(mres);
          mreq    = '{start: 1'b1, a: cds_pkg::zx31(x_d), b: cds_pkg::zx31(x_d)};
          state_d = ST_X2;
        end
      end
      ST_X2: begin
        if (!mul_busy) begin
          x2_d    = cds_pkg::clamp31(mres);
          mreq    = '{start: 1'b1, a: cds_pkg::zx31(x2_d), b: cds_pkg::zx31(x_q)};
          state_d = ST_X3;
        end
      end
      ST_X3: begin
        if (!mul_busy) begin
          x3_d    = cds_pkg::clamp31(mres);
          den_d   = (cds_pkg::DVW'(1) << FRAC_BITS) + cds_pkg::DVW'(x_q);
          mreq    = '{start: 1'b1, a: C048, b: cds_pkg::zx31(x2_q)};
          state_d = ST_T2;
        end
      end
      ST_T2: begin
        if (!mul_busy) begin
          den_d   = den_q + mres[cds_pkg::DVW-1:0];
          mreq    = '{start: 1'b1, a: C0235, b: cds_pkg::zx31(x3_q)};
          state_d = ST_T3;
        end
      end
      ST_T3: begin
        if (!mul_busy) begin
          // denominator complete: start the decay division alongside
          den_d       = den_q + mres[cds_pkg::DVW-1:0];
          div_start   = 1'b1;
          div_divisor = den_d;
          mreq        = '{start: 1'b1, a: cds_pkg::zx31(max_speed_q),
                          b: cds_pkg::zx31(st_q)};
          state_d     = ST_MAXC;
        end
      end
      ST_MAXC: begin
        if (!mul_busy) begin
          maxc_d  = mres;
          state_d = ST_CHG;
        end
      end
      ST_CHG: begin
        chg_d   = cds_pkg::clamp(cds_pkg::sx32(cur_q) - cds_pkg::sx32(tgt_q),
                                 -maxc_q, maxc_q);
        state_d = ST_CO;
      end
      ST_CO: begin
        mreq    = '{start: 1'b1, a: chg_q, b: cds_pkg::zx31(omega_q)};
        state_d = ST_TA;
      end
      ST_TA: begin
        if (!mul_busy) begin
          mreq    = '{start: 1'b1, a: cds_pkg::sx32(velocity_q) + mres,
                      b: cds_pkg::zx31(dt_q)};
          state_d = ST_TB;
        end
      end
      ST_TB: begin
        if (!mul_busy) begin
          tmp_d   = mres;
          mreq    = '{start: 1'b1, a: mres, b: cds_pkg::zx31(omega_q)};
          state_d = ST_TO;
        end
      end
      ST_TO: begin
        if (!mul_busy) begin
          vmt_d   = cds_pkg::sx32(velocity_q) - mres;
          state_d = ST_WE;
        end
      end
      ST_WE: begin
        if (!div_busy) begin
          e_d     = quot[EW-1:0];
          mreq    = '{start: 1'b1, a: vmt_q, b: cds_pkg::word_t'(e_d)};
          state_d = ST_VEL;
        end
      end
      ST_VEL: begin
        if (!mul_busy) begin
          vel_d   = mres;
          mreq    = '{start: 1'b1, a: chg_q + tmp_q, b: cds_pkg::word_t'(e_q)};
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        if (!mul_busy) begin
          pos_d   = cds_pkg::sx32(cur_q) - chg_q + mres;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_pos_d   = cds_pkg::sat32(pos_f);
          out_vel_d   = cds_pkg::sat32(vel_f);
          velocity_d  = out_vel_d;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      smooth_time_q <= 31'(1) << FRAC_BITS;
      max_speed_q   <= 31'h7FFFFFFF;
      velocity_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      smooth_time_q <= smooth_time_d;
      max_speed_q   <= max_speed_d;
      velocity_q    <= velocity_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    tgt_q     <= tgt_d;
    dt_q      <= dt_d;
    st_q      <= st_d;
    omega_q   <= omega_d;
    x_q       <= x_d;
    x2_q      <= x2_d;
    x3_q      <= x3_d;
    den_q     <= den_d;
    e_q       <= e_d;
    maxc_q    <= maxc_d;
    chg_q     <= chg_d;
    tmp_q     <= tmp_d;
    vmt_q     <= vmt_d;
    vel_q     <= vel_d;
    pos_q     <= pos_d;
    out_pos_q <= out_pos_d;
    out_vel_q <= out_vel_d;
  end

  // channel outputs
  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.new_pos      = out_pos_q;
  assign out_o.new_velocity = out_vel_q;

endmodule

`default_nettype wire
